/* hw/rtl/size_class_free_list_allocator_assert.svh */
// Assertion macros shared by the allocator RTL.
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCFL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCFL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/scfl_pkg.sv */
// Constants, codes and size-class functions of the free-list allocator.
package scfl_pkg;

	localparam int unsigned NumClasses = 377;
	localparam int ClassW = $clog2(NumClasses);

	localparam logic [15:0] NullLink   = 16'hFFFF;
	localparam logic [15:0] MaxRequest = 16'd32760;
	localparam logic [17:0] ClassBias  = 18'(120 << 7);

	localparam logic OpAlloc = 1'b0;
	localparam logic OpFree  = 1'b1;

	typedef enum logic [1:0] {
		StOk          = 2'd0,
		StOutOfMemory = 2'd1,
		StTooLarge    = 2'd2
	} status_t;

	// 8-byte classes up to 1024 bytes, 128-byte classes above
	function automatic logic [9:0] class_of(input logic [16:0] bytes);
		logic [17:0] wide;
		if (bytes <= 17'd1024) begin
			wide = (18'(bytes) + 18'd7) >> 3;
		end else begin
			wide = (18'(bytes) + 18'd127 + ClassBias) >> 7;
		end
		return wide[9:0];
	endfunction

	function automatic logic [15:0] class_bytes(input logic [ClassW-1:0] c);
		if (c <= ClassW'(128)) begin
			return 16'(c) << 3;
		end
		return 16'd1024 + (16'(c - ClassW'(128)) << 7);
	endfunction

	// log2 of the number of blocks carved per refill
	function automatic logic [3:0] chunk_shift(input logic [15:0] size);
		if (size <= 16'd24) return 4'd8;
		if (size <= 16'd64) return 4'd7;
		if (size <= 16'd128) return 4'd5;
		if (size <= 16'd1024) return 4'd3;
		if (size <= 16'd4096) return 4'd4;
		return 4'd0;
	endfunction

endpackage

/* hw/rtl/scfl_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module scfl_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/size_class_free_list_allocator.sv */
// Top level of the size-class free-list allocator: sequencer and both memories.
//
// Usage: raise start with operation, request_bytes and block_address; the item
// is taken at a clock edge where start is high and busy is low. Exactly one
// result per item comes back on user_address and status, marked by done for
// one cycle. The receiver cannot stall, so results are never held.
// Allocate: when the class list holds a block, the item reads the list head, reads
// the link and writes back, and the result is registered with the write-back.
// An empty list swaps the link read for a refill that writes one link per cycle
// through the single heap port, one link for each carved block.
// Too-large requests and frees of a bad address are answered from the accept
// state alone; out-of-memory and frees of a bad header after one memory read;
// a good free after header read, head read and write-back.
// A new item may be taken in the cycle in which done is shown.
// After reset the list-head memory is swept to empty, one class a cycle; busy stays
// high until all 377 heads are cleared. Heap contents are undefined until written.
`include "size_class_free_list_allocator_assert.svh"

module size_class_free_list_allocator #(
	parameter int unsigned HEAP_WORDS = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [15:0] request_bytes,
	input  logic [17:0] block_address,
	output logic        done,
	output logic [17:0] user_address,
	output logic [1:0]  status
);

	import scfl_pkg::*;

	localparam int WordW = $clog2(HEAP_WORDS);
	localparam int BumpW = $clog2(HEAP_WORDS + 1);
	localparam logic [16:0] HeapLimit = 17'(HEAP_WORDS);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HEAD,
		S_FILL,
		S_NEXT,
		S_POP,
		S_HDR,
		S_FHEAD
	} state_t;

	state_t             state_q;
	logic [ClassW-1:0]  clr_q;
	logic [ClassW-1:0]  cls_q;
	logic [15:0]        size_q;
	logic [15:0]        head_q;
	logic [15:0]        next_q;
	logic [15:0]        word_q;
	logic [BumpW-1:0]   bump_q;
	logic [16:0]        fill_w_q;
	logic [7:0]         fill_i_q;
	logic [7:0]         last_i_q;
	logic [12:0]        step_q;
	logic               done_q;
	logic [17:0]        user_address_q;
	status_t            status_q;

	// memory ports
	logic               heap_we, heap_re;
	logic [WordW-1:0]   heap_waddr, heap_raddr;
	logic [15:0]        heap_wdata, heap_rdata;
	logic               heads_we, heads_re;
	logic [ClassW-1:0]  heads_waddr, heads_raddr;
	logic [15:0]        heads_wdata, heads_rdata;

	logic               accept;
	logic               too_large;
	logic [ClassW-1:0]  req_cls;
	logic [15:0]        req_size;
	logic [16:0]        free_word;
	logic               free_ok;
	logic               head_valid;
	logic               next_valid;
	logic [3:0]         lg;
	logic [12:0]        step;
	logic [16:0]        chunk_words;
	logic [16:0]        remaining;
	logic [9:0]         hdr_cls;
	logic               fill_last;

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;

	// decode straight from the ports so the first read issues in the accept cycle
	assign too_large = request_bytes > MaxRequest;
	assign req_cls   = ClassW'(class_of(17'(request_bytes) + 17'd8));
	assign req_size  = class_bytes(req_cls);
	assign free_word = 17'(block_address[17:3]) - 17'd1;
	assign free_ok   = (block_address[17:3] != 15'd0) && (free_word < HeapLimit);

	assign head_valid = (heads_rdata != NullLink) && (17'(heads_rdata) < HeapLimit);
	assign next_valid = (next_q != NullLink) && (17'(next_q) < HeapLimit);

	assign lg          = chunk_shift(size_q);
	assign step        = size_q[15:3];
	assign chunk_words = 17'(step) << lg;
	assign remaining   = HeapLimit - 17'(bump_q);
	assign hdr_cls     = class_of(17'(heap_rdata));
	assign fill_last   = fill_i_q == last_i_q;

	always_comb begin
		heap_we     = 1'b0;
		heap_waddr  = WordW'(fill_w_q);
		heap_wdata  = fill_last ? NullLink : 16'(fill_w_q + 17'(step_q));
		heap_re     = 1'b0;
		heap_raddr  = WordW'(free_word);
		heads_we    = 1'b0;
		heads_waddr = clr_q;
		heads_wdata = NullLink;
		heads_re    = 1'b0;
		heads_raddr = req_cls;
		unique case (state_q)
			S_CLEAR: begin
				heads_we = 1'b1;
			end
			S_IDLE: begin
				if (accept && operation == OpAlloc && !too_large) begin
					heads_re = 1'b1;
				end
				if (accept && operation == OpFree && free_ok) begin
					heap_re = 1'b1;
				end
			end
			S_HEAD: begin
				heap_re    = head_valid;
				heap_raddr = WordW'(heads_rdata);
			end
			S_FILL: begin
				heap_we = 1'b1;
			end
			S_NEXT: begin
			end
			S_POP: begin
				heap_we     = 1'b1;
				heap_waddr  = WordW'(head_q);
				heap_wdata  = size_q;
				heads_we    = 1'b1;
				heads_waddr = cls_q;
				heads_wdata = next_valid ? next_q : NullLink;
			end
			S_HDR: begin
				heads_re    = hdr_cls < 10'(NumClasses);
				heads_raddr = ClassW'(hdr_cls);
			end
			S_FHEAD: begin
				heap_we     = 1'b1;
				heap_waddr  = WordW'(word_q);
				heap_wdata  = heads_rdata;
				heads_we    = 1'b1;
				heads_waddr = cls_q;
				heads_wdata = word_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			cls_q          <= '0;
			size_q         <= '0;
			head_q         <= '0;
			next_q         <= '0;
			word_q         <= '0;
			bump_q         <= '0;
			fill_w_q       <= '0;
			fill_i_q       <= '0;
			last_i_q       <= '0;
			step_q         <= '0;
			done_q         <= 1'b0;
			user_address_q <= '0;
			status_q       <= StOk;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ClassW'(1);
					if (clr_q == ClassW'(NumClasses - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cls_q          <= req_cls;
						size_q         <= req_size;
						word_q         <= 16'(free_word);
						user_address_q <= '0;
						status_q       <= StOk;
						if (operation == OpAlloc) begin
							if (too_large) begin
								status_q <= StTooLarge;
								done_q   <= 1'b1;
							end else begin
								state_q <= S_HEAD;
							end
						end else if (free_ok) begin
							state_q <= S_HDR;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_HEAD: begin
					if (head_valid) begin
						head_q  <= heads_rdata;
						state_q <= S_NEXT;
					end else if (chunk_words > remaining) begin
						status_q <= StOutOfMemory;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						// carve a fresh chunk from the bump region
						head_q   <= 16'(bump_q);
						fill_w_q <= 17'(bump_q);
						fill_i_q <= '0;
						last_i_q <= 8'((9'd1 << lg) - 9'd1);
						step_q   <= step;
						bump_q   <= BumpW'(17'(bump_q) + chunk_words);
						state_q  <= S_FILL;
					end
				end
				S_FILL: begin
					fill_w_q <= fill_w_q + 17'(step_q);
					fill_i_q <= fill_i_q + 8'd1;
					if (fill_last) begin
						// link of the fresh head is known without reading it back
						next_q  <= (last_i_q == 8'd0) ? NullLink
							: 16'(17'(head_q) + 17'(step_q));
						state_q <= S_POP;
					end
				end
				S_NEXT: begin
					next_q  <= heap_rdata;
					state_q <= S_POP;
				end
				S_POP: begin
					user_address_q <= 18'((20'(head_q) + 20'd1) << 3);
					done_q         <= 1'b1;
					state_q        <= S_IDLE;
				end
				S_HDR: begin
					cls_q <= ClassW'(hdr_cls);
					if (hdr_cls < 10'(NumClasses)) begin
						state_q <= S_FHEAD;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_FHEAD: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign user_address = user_address_q;
	assign status       = status_q;

	scfl_ram #(
		.WIDTH(16),
		.DEPTH(HEAP_WORDS)
	) u_heap_ram (
		.clk  (clk),
		.we   (heap_we),
		.waddr(heap_waddr),
		.wdata(heap_wdata),
		.re   (heap_re),
		.raddr(heap_raddr),
		.rdata(heap_rdata)
	);

	scfl_ram #(
		.WIDTH(16),
		.DEPTH(NumClasses)
	) u_heads_ram (
		.clk  (clk),
		.we   (heads_we),
		.waddr(heads_waddr),
		.wdata(heads_wdata),
		.re   (heads_re),
		.raddr(heads_raddr),
		.rdata(heads_rdata)
	);

	`SCFL_ASSERT_NXT(a_too_large_resp, clk, arst_n, accept && operation == OpAlloc && too_large, done && status == StTooLarge && user_address == 18'd0, "too-large item not answered at once")
	`SCFL_ASSERT_NXT(a_pop_resp, clk, arst_n, state_q == S_POP, done && status == StOk, "pop did not deliver a granted block")
	`SCFL_ASSERT_IMP(a_fill_bound, clk, arst_n, state_q == S_FILL, fill_i_q <= last_i_q, "refill ran past its block count")
	`SCFL_ASSERT_IMP(a_bump_bound, clk, arst_n, 1'b1, 17'(bump_q) <= HeapLimit, "bump region overran the heap")

endmodule

/* tb/scfl_checker.sv */
// Checker for the free-list allocator: predicts each result and compares it with the block.
module scfl_checker #(
	parameter int unsigned HeapWords = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        operation,
	input  logic [15:0] request_bytes,
	input  logic [17:0] block_address,
	input  logic        done,
	input  logic [17:0] user_address,
	input  logic [1:0]  status,
	input  logic        run_over,
	output int          errors
);

	import scfl_pkg::*;

	typedef struct packed {
		logic [17:0] addr;
		status_t     st;
	} grant_t;

	logic [15:0] list_head [NumClasses];
	logic [15:0] heap_mem [HeapWords];
	int unsigned carve_word;
	int unsigned heap_left;

	grant_t expected_grants [$];
	int err_count = 0;
	int n_granted = 0;
	int n_fresh = 0;
	int n_oom = 0;
	int n_too_large = 0;
	int n_free = 0;
	int n_ignored = 0;

	assign errors = err_count;

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		err_count++;
	endtask

	function automatic int unsigned size_class(input int unsigned bytes);
		if (bytes <= 1024) return (bytes + 7) >> 3;
		return (bytes + 127 + (120 << 7)) >> 7;
	endfunction

	function automatic int unsigned class_size(input int unsigned c);
		if (c <= 128) return c << 3;
		return 1024 + ((c - 128) << 7);
	endfunction

	function automatic int unsigned chunk_blocks(input int unsigned s);
		if (s <= 24) return 256;
		if (s <= 64) return 128;
		if (s <= 128) return 32;
		if (s <= 1024) return 8;
		if (s <= 4096) return 16;
		return 1;
	endfunction

	function automatic bit link_ok(input int unsigned w);
		return w != 32'(NullLink) && w < HeapWords;
	endfunction

	// Apply one request to the shadow heap and return the result it should give.
	function automatic grant_t serve(input logic op, input logic [15:0] req,
			input logic [17:0] addr);
		grant_t g;
		int unsigned c, s, hd, nx, n, chunk, step, w, hdr, i;
		g.addr = '0;
		g.st = StOk;
		if (op == OpAlloc) begin
			if (req > MaxRequest) begin
				g.st = StTooLarge;
				n_too_large++;
				return g;
			end
			c = size_class(32'(req) + 8);
			s = class_size(c);
			hd = list_head[c];
			if (!link_ok(hd)) begin
				n = chunk_blocks(s);
				chunk = n * s;
				step = s >> 3;
				if (chunk > heap_left) begin
					g.st = StOutOfMemory;
					n_oom++;
					return g;
				end
				// link the fresh chunk in address order
				w = carve_word;
				for (i = 0; i < n; i++) begin
					if (w < HeapWords) heap_mem[w] = (i + 1 < n) ? 16'(w + step) : NullLink;
					w += step;
				end
				hd = carve_word;
				carve_word += chunk >> 3;
				heap_left -= chunk;
				n_fresh++;
				if (!link_ok(hd)) begin
					g.st = StOutOfMemory;
					n_oom++;
					return g;
				end
			end
			nx = heap_mem[hd];
			list_head[c] = link_ok(nx) ? 16'(nx) : NullLink;
			heap_mem[hd] = 16'(s);
			g.addr = 18'((hd + 1) << 3);
			n_granted++;
			return g;
		end
		n_free++;
		w = 32'(addr) >> 3;
		if (w == 0) begin
			n_ignored++;
			return g;
		end
		w -= 1;
		if (w >= HeapWords) begin
			n_ignored++;
			return g;
		end
		hdr = heap_mem[w];
		c = size_class(hdr);
		if (c >= NumClasses) begin
			n_ignored++;
			return g;
		end
		heap_mem[w] = list_head[c];
		list_head[c] = 16'(w);
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			for (int k = 0; k < NumClasses; k++) list_head[k] = NullLink;
			carve_word = 0;
			heap_left = HeapWords * 8;
			expected_grants.delete();
		end else begin
			// results belong to earlier items, so match them before taking a new one
			if (done) begin
				if (expected_grants.size() == 0) begin
					report($sformatf("result with nothing expected: address %0d status %0d",
						user_address, status));
				end else begin
					want = expected_grants.pop_front();
					if (user_address !== want.addr)
						report($sformatf("user_address %0d, expected %0d", user_address, want.addr));
					if (status !== want.st)
						report($sformatf("status %0d, expected %s", status, want.st.name()));
				end
			end
			if (start && !busy)
				expected_grants.push_back(serve(operation, request_bytes, block_address));
		end
	end

	always @(posedge run_over) begin
		while (expected_grants.size() > 0) begin
			void'(expected_grants.pop_front());
			report("expected result never arrived");
		end
		$display("coverage: %0d allocations granted, %0d of them from a fresh chunk, %0d %s",
			n_granted, n_fresh, n_oom, "out of memory");
		$display("coverage: %0d too large, %0d frees, %0d ignored for a bad address or header",
			n_too_large, n_free, n_ignored);
	end

endmodule

/* tb/tb_size_class_free_list_allocator.sv */
// Testbench top for the free-list allocator: clock, reset, request stimulus and verdict.
module tb_size_class_free_list_allocator;
	import scfl_pkg::*;

	localparam int unsigned HeapWords = 32768;
	localparam int StallLimit = 4000;
	localparam int RandomItems = 1400;
	localparam int DrainItems = 200;
	localparam logic [15:0] BoundarySizes [9] = '{
		16'd0, 16'd1, 16'd120, 16'd121, 16'd1016, 16'd1017, 16'd4088, 16'd4089, 16'd32760
	};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        operation;
	logic [15:0] request_bytes;
	logic [17:0] block_address;
	logic        done;
	logic [17:0] user_address;
	logic [1:0]  status;
	logic        run_over;
	int          errors;

	// stimulus bookkeeping: live blocks that may be freed, items sent and answered
	logic [17:0] live_blocks [$];
	logic        op_in_flight [$];
	int          sent = 0;
	int          answered = 0;
	status_t     last_status = StOk;
	bit          gaps_on = 1'b1;
	int          quiet = 0;

	size_class_free_list_allocator #(
		.HEAP_WORDS(HeapWords)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.request_bytes(request_bytes),
		.block_address(block_address),
		.done         (done),
		.user_address (user_address),
		.status       (status)
	);

	scfl_checker #(
		.HeapWords(HeapWords)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.request_bytes(request_bytes),
		.block_address(block_address),
		.done         (done),
		.user_address (user_address),
		.status       (status),
		.run_over     (run_over),
		.errors       (errors)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// track granted blocks so that only live ones are freed, never twice
	always @(posedge clk) begin
		logic op;
		if (arst_n) begin
			if (done) begin
				op = op_in_flight.size() > 0 ? op_in_flight.pop_front() : OpFree;
				last_status = status_t'(status);
				if (op == OpAlloc && status == StOk) live_blocks.push_back(user_address);
				answered++;
			end
			if (start && !busy) op_in_flight.push_back(operation);
		end
	end

	always @(posedge clk) begin
		if (arst_n && ((start && !busy) || done)) begin
			quiet = 0;
		end else begin
			quiet++;
		end
		if (quiet >= StallLimit) begin
			$display("watchdog: no item or result for %0d cycles", StallLimit);
			$display("** size_class_free_list_allocator: FAILED **");
			$finish;
		end
	end

	task automatic issue(input logic op, input logic [15:0] req, input logic [17:0] addr);
		while (gaps_on && $urandom_range(0, 99) < 29) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		request_bytes <= req;
		block_address <= addr;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (answered != sent) @(posedge clk);
	endtask

	initial begin
		logic [17:0] blk;
		logic [15:0] req;
		int pick, sel, slot, cls, tries, drained;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OpAlloc;
		request_bytes = '0;
		block_address = '0;
		run_over = 1'b0;
		drained = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// first allocation carves the smallest class from word 0; its last block ends the list
		issue(OpAlloc, 16'd0, 18'($urandom));
		issue(OpAlloc, 16'd0, 18'($urandom));
		issue(OpFree, 16'($urandom), 18'd2048);
		issue(OpFree, 16'($urandom), 18'd2055);
		issue(OpFree, 16'($urandom), 18'd0);
		issue(OpFree, 16'($urandom), 18'd7);
		wait_idle();
		blk = live_blocks.pop_front();
		issue(OpFree, 16'($urandom), blk | 18'd5);
		issue(OpAlloc, 16'd0, 18'($urandom));
		issue(OpAlloc, 16'd32761, 18'($urandom));
		issue(OpAlloc, 16'hFFFF, 18'($urandom));
		foreach (BoundarySizes[i]) issue(OpAlloc, BoundarySizes[i], 18'($urandom));
		issue(OpAlloc, 16'd16, 18'($urandom));
		issue(OpAlloc, 16'd56, 18'($urandom));
		issue(OpAlloc, 16'd57, 18'($urandom));

		for (int k = 0; k < RandomItems; k++) begin
			gaps_on = (k < 500 || k >= 750);
			if (k == 1100) wait_idle();
			pick = $urandom_range(0, 99);
			if (live_blocks.size() > 0 && (pick < 40 || (live_blocks.size() > 48 && pick < 75))) begin
				slot = $urandom_range(0, live_blocks.size() - 1);
				blk = live_blocks[slot];
				live_blocks.delete(slot);
				issue(OpFree, 16'($urandom), blk | 18'($urandom_range(0, 7)));
			end else if (pick >= 97) begin
				issue(OpFree, 16'($urandom), 18'($urandom_range(0, 7)));
			end else begin
				sel = $urandom_range(0, 99);
				if (sel < 55) req = 16'($urandom_range(0, 120));
				else if (sel < 72) req = 16'($urandom_range(121, 1016));
				else if (sel < 80) req = 16'($urandom_range(1017, 32760));
				else if (sel < 90) req = BoundarySizes[$urandom_range(0, 8)];
				else req = 16'($urandom_range(32761, 65535));
				issue(OpAlloc, req, 18'($urandom));
			end
		end

		// drain classes from the largest down until they run dry, within a fixed item budget
		for (cls = NumClasses - 1; cls >= 1 && drained < DrainItems; cls--) begin
			tries = 0;
			do begin
				issue(OpAlloc, class_bytes(ClassW'(cls)) - 16'd8, 18'($urandom));
				wait_idle();
				tries++;
				drained++;
			end while (last_status != StOutOfMemory && tries < 300 && drained < DrainItems);
		end

		wait_idle();
		repeat (300) @(posedge clk);
		run_over <= 1'b1;
		@(posedge clk);
		@(posedge clk);
		if (errors == 0) begin
			$display("** size_class_free_list_allocator: PASSED **");
		end else begin
			$display("** size_class_free_list_allocator: FAILED **");
		end
		$finish;
	end

endmodule
